@@ hw/rtl/promotable_priority_table_unit_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef PROMOTABLE_PRIORITY_TABLE_UNIT_MACROS_SVH
`define PROMOTABLE_PRIORITY_TABLE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/ppt_pkg.sv @@
// Package with types and codes of the promotable priority table.
`timescale 1ns / 1ps
package ppt_pkg;
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_PROMOTE = 3'd2;
  localparam logic [2:0] OP_GET_MAX = 3'd3;
  localparam logic [2:0] OP_POP_MAX = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] obj_value;
    logic [31:0] item_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] result_id;
    logic [31:0] result_value;
    logic [15:0] result_priority;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_DONE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic apply;
    logic emit;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic scan_last;
  } sts_t;
endpackage

@@ hw/rtl/ppt_ctrl.sv @@
// Controller state machine sequencing one transaction through the scan.
`timescale 1ns / 1ps
module ppt_ctrl import ppt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  sts_t   sts_i,
  output logic   busy_o,
  output cmd_t   cmd_o
);
  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_SCAN;
      S_SCAN: if (sts_i.scan_last) state_d = S_APPLY;
      S_APPLY: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load = start_i;
        cmd_o.scan_clr = start_i;
      end
      S_SCAN: cmd_o.scan_step = 1'b1;
      S_APPLY: cmd_o.apply = 1'b1;
      S_DONE: cmd_o.emit = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ hw/rtl/ppt_datapath.sv @@
// Datapath: slot storage, one-slot-per-cycle scan and result register.
`timescale 1ns / 1ps
module ppt_datapath import ppt_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int VALUE_BITS = 32,
  parameter int LEVEL_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic done_o,
  output rsp_t rsp_o
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  logic [SLOTS-1:0] valid_q;
  logic [31:0] ident_mem [SLOTS];
  logic [VALUE_BITS-1:0] payload_mem [SLOTS];
  logic [LEVEL_BITS-1:0] level_mem [SLOTS];
  logic [31:0] next_ident_q;

  req_t req_q;
  logic [IW-1:0] idx_q;
  logic hit_q;
  logic [IW-1:0] hit_idx_q;
  logic [31:0] hit_id_q;
  logic [VALUE_BITS-1:0] hit_val_q;
  logic [LEVEL_BITS-1:0] hit_lvl_q;
  rsp_t rsp_q;
  rsp_t rsp_d;
  logic done_q;

  // Read address: the slot that the scan pointer holds after this edge, so
  // the registered read data always belongs to the slot under the pointer.
  logic [IW-1:0] rd_addr;
  always_comb begin
    rd_addr = idx_q;
    if (cmd_i.scan_clr) begin
      rd_addr = '0;
    end else if (cmd_i.scan_step && (idx_q != LAST)) begin
      rd_addr = idx_q + 1'b1;
    end
  end

  // Registered read of the slot store.
  logic [31:0] rd_id_q;
  logic [VALUE_BITS-1:0] rd_val_q;
  logic [LEVEL_BITS-1:0] rd_lvl_q;
  always_ff @(posedge clk_i) begin
    rd_id_q <= ident_mem[rd_addr];
    rd_val_q <= payload_mem[rd_addr];
    rd_lvl_q <= level_mem[rd_addr];
  end

  logic rd_v;
  assign rd_v = valid_q[idx_q];

  assign sts_o.scan_last = cmd_i.scan_step && (idx_q == LAST);

  // Decide whether the current slot replaces the held candidate.
  logic take;
  always_comb begin
    take = 1'b0;
    case (req_q.op)
      OP_ADD: take = !rd_v && !hit_q;
      OP_LOOKUP, OP_PROMOTE: take = rd_v && !hit_q && (rd_id_q == req_q.item_id);
      OP_GET_MAX, OP_POP_MAX:
        take = rd_v && (!hit_q || rd_lvl_q > hit_lvl_q ||
               (rd_lvl_q == hit_lvl_q && rd_id_q > hit_id_q));
      default: take = 1'b0;
    endcase
  end

  // Scan registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hit_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (idx_q != LAST) idx_q <= idx_q + 1'b1;
        if (take) hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.scan_step && take) begin
      hit_idx_q <= idx_q;
      hit_id_q <= rd_id_q;
      hit_val_q <= rd_val_q;
      hit_lvl_q <= rd_lvl_q;
    end
  end

  // Promoted level with saturation.
  logic [LEVEL_BITS-1:0] up_lvl;
  assign up_lvl = (hit_lvl_q == LEVEL_MAX) ? hit_lvl_q : hit_lvl_q + 1'b1;

  // Table update and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      next_ident_q <= '0;
    end else if (cmd_i.apply && hit_q) begin
      case (req_q.op)
        OP_ADD: begin
          valid_q[hit_idx_q] <= 1'b1;
          next_ident_q <= next_ident_q + 32'd1;
        end
        OP_POP_MAX: valid_q[hit_idx_q] <= 1'b0;
        default: valid_q <= valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && hit_q) begin
      case (req_q.op)
        OP_ADD: begin
          ident_mem[hit_idx_q] <= next_ident_q;
          payload_mem[hit_idx_q] <= VALUE_BITS'(req_q.obj_value);
          level_mem[hit_idx_q] <= '0;
        end
        OP_PROMOTE: level_mem[hit_idx_q] <= up_lvl;
        default: level_mem[hit_idx_q] <= level_mem[hit_idx_q];
      endcase
    end
  end

  // Result register.
  logic [31:0] val32;
  logic [15:0] lvl16;
  logic [LEVEL_BITS-1:0] rep_lvl;
  assign rep_lvl = (req_q.op == OP_PROMOTE) ? up_lvl : hit_lvl_q;
  assign val32 = 32'(hit_val_q);
  assign lvl16 = 16'(rep_lvl);

  always_comb begin
    rsp_d = '0;
    case (req_q.op)
      OP_ADD: begin
        if (hit_q) rsp_d.result_id = next_ident_q;
        else rsp_d.status = ST_FULL;
      end
      OP_LOOKUP, OP_PROMOTE, OP_GET_MAX, OP_POP_MAX: begin
        if (hit_q) begin
          rsp_d.found = 1'b1;
          rsp_d.result_id = hit_id_q;
          rsp_d.result_value = val32;
          rsp_d.result_priority = lvl16;
        end else if (req_q.op == OP_LOOKUP || req_q.op == OP_PROMOTE) begin
          rsp_d.status = ST_NOT_FOUND;
        end else begin
          rsp_d.status = ST_EMPTY;
        end
      end
      default: rsp_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o = rsp_q;
endmodule

@@ hw/rtl/promotable_priority_table_unit.sv @@
// Top level of the promotable priority table.
// Usage: drive req_i and raise start while busy is low; the transaction
// is accepted on that edge and busy rises. The unit scans all SLOTS slots,
// one per cycle, to find a free slot, a matching id or the maximum, then
// applies the update. The result appears on rsp_o with done_o high for
// exactly one cycle; busy drops in the same cycle, and rsp_o holds the
// result until the next transaction applies. The single scan pointer over
// the slot store means a new transaction is taken only once busy is low.
// Ops: add, lookup, promote, get max, pop max; failures are reported in
// the status field with other fields zero.
// Reset empties the table and clears the id counter; no clearing pass is
// needed. The receiver cannot stall: each result must be taken when shown.
`timescale 1ns / 1ps
module promotable_priority_table_unit import ppt_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int VALUE_BITS = 32,
  parameter int LEVEL_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);
  cmd_t cmd;
  sts_t sts;

  ppt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  ppt_datapath #(
    .SLOTS     (SLOTS),
    .VALUE_BITS(VALUE_BITS),
    .LEVEL_BITS(LEVEL_BITS)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );
endmodule

@@ hw/rtl/ppt_checker.sv @@
// Port-level checker of the promotable priority table, with its bind.
`timescale 1ns / 1ps
`include "promotable_priority_table_unit_macros.svh"
module ppt_checker import ppt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);
  // An accepted transaction makes the unit busy.
  `PPT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // A result is shown for one cycle only.
  `PPT_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  // A result comes only while idle again.
  `PPT_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // Found results always report ok.
  `PPT_ASSERT_IMP(a_found_ok, clk_i, rst_ni, done_o && rsp_o.found, rsp_o.status == ST_OK)
endmodule

bind promotable_priority_table_unit ppt_checker u_ppt_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
